@@ src/clf_pkg.sv @@
package clf_pkg;

  localparam int GREY_W   = 8;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int BASE_W   = 6;
  localparam int GAIN_W   = 24;
  localparam int THR_W    = 11;
  localparam int SPEED_W  = 8;
  localparam int SUM_W    = 28;
  localparam int AREA_W   = 25;
  localparam int AVG_W    = 8;
  localparam int ERR_W    = 11;
  localparam int INTEG_W  = 26;
  localparam int NUM_W    = 56;
  localparam int NWIN     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_BASE   = 3'd2,
    REG_KP     = 3'd3,
    REG_KI     = 3'd4,
    REG_KD     = 3'd5,
    REG_THR    = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_BOUNDS,
    ST_AREA,
    ST_DIV,
    ST_DIV_NEXT,
    ST_CHECK,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SPEED_L,
    ST_SPEED_R,
    ST_OUT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;
    logic bounds;
    logic area;
    logic div_start;
    logic div_step;
    logic div_store;
    logic check;
    logic err;
    logic mul_p;
    logic mul_i;
    logic mul_d;
    logic speed_l;
    logic speed_r;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_win;
    logic lost;
  } dp_status_t;

endpackage

@@ src/clf_stream_if.sv @@
interface clf_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/clf_ctrl.sv @@
module clf_ctrl
  import clf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_last,
  input  logic       out_taken,
  input  dp_status_t status,
  output ctl_cmd_t   cmd,
  output logic       in_ready,
  output logic       out_valid
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_ACCUM: begin
        in_ready = 1'b1;
        cmd.accum = in_fire;
        if (in_fire && in_last) state_nxt = ST_BOUNDS;
      end
      ST_BOUNDS: begin
        cmd.bounds = 1'b1;
        state_nxt = ST_AREA;
      end
      ST_AREA: begin
        cmd.area = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV_NEXT;
      end
      ST_DIV_NEXT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt = status.last_win ? ST_CHECK : ST_BOUNDS;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        if (status.lost) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.err = 1'b1;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_i = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_SPEED_L;
      end
      ST_SPEED_L: begin
        cmd.speed_l = 1'b1;
        state_nxt = ST_SPEED_R;
      end
      ST_SPEED_R: begin
        cmd.speed_r = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_taken) begin
          cmd.clear = 1'b1;
          state_nxt = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

endmodule

@@ src/clf_datapath.sv @@
module clf_datapath
  import clf_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_status_t            status,
  input  logic [GREY_W-1:0]     grey,
  input  logic [COORD_W-1:0]    column,
  input  logic [COORD_W-1:0]    row,
  input  logic [DIM_W-1:0]      frame_width,
  input  logic [DIM_W-1:0]      frame_height,
  input  logic [BASE_W-1:0]     base_speed,
  input  logic [GAIN_W-1:0]     gain_prop,
  input  logic [GAIN_W-1:0]     gain_integ,
  input  logic [GAIN_W-1:0]     gain_deriv,
  input  logic [THR_W-1:0]      lost_threshold,
  output logic signed [SPEED_W-1:0] left_cmd,
  output logic signed [SPEED_W-1:0] right_cmd,
  output logic                  line_lost
);

  localparam int BND_W = $clog2(MAX_DIMENSION + 1);
  localparam logic [BND_W-1:0] MAXD = BND_W'(MAX_DIMENSION);
  localparam int PROD_W = DIM_W + 5;

  // Clip a scaled width or height to the addressable range.
  function automatic logic [BND_W-1:0] clip(input logic [PROD_W-1:0] v);
    clip = (v > PROD_W'(MAX_DIMENSION)) ? MAXD : v[BND_W-1:0];
  endfunction

  // Divide by 20 through a reciprocal with one correction step.
  function automatic logic [PROD_W-1:0] div20(input logic [PROD_W-1:0] v);
    logic [PROD_W+16-1:0] p;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] r;
    p = v * 17'd52429;
    q = PROD_W'(p >> 20);
    r = v - q * PROD_W'(20);
    div20 = (r >= PROD_W'(20)) ? q + 1'b1 : q;
  endfunction

  // Window bounds. The column bounds are registered from the next width value,
  // so they change at the same edge as the width register.
  logic [BND_W-1:0] col_lo [NWIN];
  logic [BND_W-1:0] col_hi [NWIN];
  logic [BND_W-1:0] row_lo, row_hi;
  logic [PROD_W-1:0] fw, fh;

  assign fw = PROD_W'(frame_width);
  assign fh = PROD_W'(frame_height);
  assign row_lo = clip((fh * PROD_W'(3)) >> 2);
  assign row_hi = clip(fh);

  for (genvar k = 0; k < NWIN; k++) begin : g_bnd
    logic [PROD_W-1:0] lo_r, hi_r;
    always_ff @(posedge clk) begin
      lo_r <= div20(fw * PROD_W'(5 + 2 * k));
      hi_r <= div20(fw * PROD_W'(7 + 2 * k));
    end
    assign col_lo[k] = clip(lo_r);
    assign col_hi[k] = clip(hi_r);
  end

  // Window accumulators.
  logic [SUM_W-1:0] sum_r [NWIN];
  logic in_rows;
  logic [GREY_W-1:0] inv;
  assign in_rows = ({1'b0, row} >= BND_W'(row_lo)) && ({1'b0, row} < BND_W'(row_hi));
  assign inv = ~grey;

  for (genvar k = 0; k < NWIN; k++) begin : g_acc
    logic hit;
    logic [SUM_W:0] s;
    assign hit = in_rows && ({1'b0, column} >= (COORD_W + 1)'(col_lo[k]))
               && ({1'b0, column} < (COORD_W + 1)'(col_hi[k]));
    assign s = {1'b0, sum_r[k]} + (SUM_W + 1)'(inv);
    always_ff @(posedge clk) begin
      if (!rst_n || cmd.clear) begin
        sum_r[k] <= '0;
      end else if (cmd.accum && hit) begin
        sum_r[k] <= s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
      end
    end
  end

  // Sequential averaging, one window at a time through a restoring divider.
  logic [2:0] win_r;
  logic [BND_W-1:0] wd_r, ht_r;
  logic [AREA_W-1:0] area_r;
  logic [SUM_W-1:0] quo_r;
  logic [AREA_W:0] rem_r;
  logic [4:0] cnt_r;
  logic [AVG_W-1:0] avg_r [NWIN];
  logic [AVG_W-1:0] avg_sel;
  logic [AREA_W:0] trial;

  assign trial = {rem_r[AREA_W-1:0], quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cmd.div_store) begin
      win_r <= (win_r == 3'(NWIN - 1)) ? 3'd0 : win_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      wd_r <= (col_hi[win_r] > col_lo[win_r]) ? col_hi[win_r] - col_lo[win_r] : '0;
      ht_r <= (row_hi > row_lo) ? row_hi - row_lo : '0;
    end
    if (cmd.area) area_r <= AREA_W'(wd_r) * AREA_W'(ht_r);
    if (cmd.div_start) begin
      quo_r <= sum_r[win_r];
      rem_r <= '0;
      cnt_r <= 5'(SUM_W);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, area_r}) begin
        rem_r <= trial - {1'b0, area_r};
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.div_store) avg_r[win_r] <= avg_sel;
  end

  assign avg_sel = (area_r == '0) ? '0 :
                   (quo_r > SUM_W'(255)) ? AVG_W'(255) : quo_r[AVG_W-1:0];
  assign status.div_done = (cnt_r == '0);
  assign status.last_win = (win_r == 3'(NWIN - 1));

  // Lost check and PID.
  logic [THR_W-1:0] total;
  logic lost_r;
  logic signed [ERR_W-1:0] e_r, prev_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W+1:0] integ_sum;
  logic signed [ERR_W+1:0] e_calc;
  logic signed [NUM_W-1:0] num_r;
  logic signed [NUM_W-1:0] term;
  logic signed [GAIN_W:0] mul_a;
  logic signed [INTEG_W:0] mul_b;
  logic signed [GAIN_W+INTEG_W+1:0] prod;
  logic signed [NUM_W+8:0] spd_l, spd_r;
  logic signed [SPEED_W-1:0] left_r, right_r;
  logic signed [NUM_W:0] one_q;

  assign total = THR_W'(avg_r[0]) + THR_W'(avg_r[1]) + THR_W'(avg_r[2])
               + THR_W'(avg_r[3]) + THR_W'(avg_r[4]);
  assign e_calc = 13'sd2 * $signed({5'd0, avg_r[4]}) + $signed({5'd0, avg_r[3]})
                - $signed({5'd0, avg_r[1]}) - 13'sd2 * $signed({5'd0, avg_r[0]});
  assign integ_sum = (INTEG_W + 2)'(integ_r) + (INTEG_W + 2)'(prev_r)
                   + (INTEG_W + 2)'(e_calc);
  assign status.lost = lost_r;

  // One shared multiplier; the factor of two on the P and D terms goes into the operand.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_p) begin
      mul_a = $signed({1'b0, gain_prop});
      mul_b = (INTEG_W + 1)'(e_r) <<< 1;
    end else if (cmd.mul_i) begin
      mul_a = $signed({1'b0, gain_integ});
      mul_b = (INTEG_W + 1)'(integ_r);
    end else if (cmd.mul_d) begin
      mul_a = $signed({1'b0, gain_deriv});
      mul_b = ((INTEG_W + 1)'(e_r) - (INTEG_W + 1)'(prev_r)) <<< 1;
    end
  end

  assign prod = mul_a * mul_b;
  assign term = NUM_W'(prod);

  assign one_q = (NUM_W + 1)'(1) <<< 25;

  // Truncate toward zero, then saturate.
  function automatic logic signed [SPEED_W-1:0] sat(input logic signed [NUM_W+8:0] p);
    logic signed [NUM_W+8:0] q;
    q = (p < 0) ? -((-p) >>> 25) : (p >>> 25);
    if (q > 127) sat = 8'sd127;
    else if (q < -128) sat = -8'sd128;
    else sat = q[SPEED_W-1:0];
  endfunction

  assign spd_l = $signed({1'b0, base_speed}) * ((NUM_W + 9)'(one_q) + (NUM_W + 9)'(num_r));
  assign spd_r = $signed({1'b0, base_speed}) * ((NUM_W + 9)'(one_q) - (NUM_W + 9)'(num_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      integ_r <= '0;
    end else begin
      if (cmd.err) begin
        e_r <= e_calc[ERR_W-1:0];
        if (integ_sum > (INTEG_W + 2)'(33554431)) integ_r <= 26'sd33554431;
        else if (integ_sum < -(INTEG_W + 2)'(33554432)) integ_r <= -26'sd33554432;
        else integ_r <= integ_sum[INTEG_W-1:0];
      end
      if (cmd.mul_d) prev_r <= e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) lost_r <= (total < lost_threshold);
    if (cmd.err) num_r <= '0;
    else if (cmd.mul_p || cmd.mul_i || cmd.mul_d) num_r <= num_r + term;
    if (cmd.speed_l) left_r <= sat(spd_l);
    if (cmd.speed_r) right_r <= sat(spd_r);
  end

  assign left_cmd  = lost_r ? -$signed({2'b0, base_speed}) : left_r;
  assign right_cmd = lost_r ? -$signed({2'b0, base_speed}) : right_r;
  assign line_lost = lost_r;

endmodule

@@ src/camera_line_follower_pid_unit.sv @@
// Line follower with PID steering. Each pixel word is taken in one cycle; inverted
// brightness is summed into five windows of the lower quarter of the frame. On
// the word flagged frame_end the block stops taking pixels: each of the five window
// averages runs in turn through a shared 28-step restoring divider, then the lost
// check and, when the line is seen, the PID terms pass one by one through a single
// multiplier. The word with both wheel speeds and the line-lost flag is offered
// once both wheel speeds are registered, or after the lost check when the line is
// lost. Pixels are taken again in the cycle after that word is taken.
// A register write takes effect for the next pixel.
module camera_line_follower_pid_unit
  import clf_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  clf_stream_if.sink            in_ch,
  clf_stream_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [DIM_W-1:0]  width_nxt;
  logic [BASE_W-1:0] base_r;
  logic [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [THR_W-1:0]  thr_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd64;
      height_r <= 13'd48;
      base_r <= 6'd3;
      kp_r <= 24'd7550;
      ki_r <= 24'd1007;
      kd_r <= 24'd10066;
      thr_r <= 11'd100;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_BASE:   base_r <= cfg_data[BASE_W-1:0];
        REG_KP:     kp_r <= cfg_data;
        REG_KI:     ki_r <= cfg_data;
        REG_KD:     kd_r <= cfg_data;
        REG_THR:    thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Next width, so the registered column bounds follow a write at the same edge.
  always_comb begin
    width_nxt = width_r;
    if (!rst_n) begin
      width_nxt = 13'd64;
    end else if (cfg_we && (cfg_reg_t'(cfg_index) == REG_WIDTH)) begin
      width_nxt = cfg_data[DIM_W-1:0];
    end
  end

  ctl_cmd_t cmd;
  dp_status_t status;
  logic in_fire, out_taken;
  logic [GREY_W-1:0] in_grey;
  logic [COORD_W-1:0] in_column, in_row;
  logic in_frame_end;
  logic signed [SPEED_W-1:0] out_left_cmd, out_right_cmd;
  logic out_line_lost;

  assign {in_grey, in_column, in_row, in_frame_end} = in_ch.data;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_taken = out_ch.valid && out_ch.ready;
  assign out_ch.data = {out_left_cmd, out_right_cmd, out_line_lost};

  clf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_frame_end),
    .out_taken(out_taken), .status(status), .cmd(cmd),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid)
  );

  clf_datapath #(.MAX_DIMENSION(MAX_DIMENSION)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .grey(in_grey), .column(in_column), .row(in_row),
    .frame_width(width_nxt), .frame_height(height_r), .base_speed(base_r),
    .gain_prop(kp_r), .gain_integ(ki_r), .gain_deriv(kd_r),
    .lost_threshold(thr_r),
    .left_cmd(out_left_cmd), .right_cmd(out_right_cmd),
    .line_lost(out_line_lost)
  );

  // A result is never offered while pixels are being taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready and valid together");
  // Frame end leaves the pixel phase.
  a_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_frame_end) |=> !in_ch.ready) else $error("frame end ignored");
  // A taken result returns to the pixel phase.
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_taken |=> in_ch.ready) else $error("no return to pixels");

endmodule
